### sv/bre_pkg.sv
`timescale 1ns / 1ps
// bre_pkg: widths, register codes, reset values and shared types of the
// breathing rate estimator. No dependencies.
package bre_pkg;

	localparam int RAW_W    = 13;
	localparam int MV_W     = 13;
	localparam int NOW_W    = 32;
	localparam int RATE_W   = 8;
	localparam int MARGIN_W = 8;
	localparam int GAP_W    = 16;
	localparam int WINDOW_W = 20;
	localparam int SCALE_W  = 4;
	localparam int CFG_W    = 20;
	localparam int CFG_IDX_W = 2;

	localparam int AVG_TAPS_DEF   = 5;
	localparam int PEAK_SLOTS_DEF = 15;
	localparam int QUEUE_DEPTH    = 2;

	// millivolt conversion: raw * 3600 / 4096
	localparam int MV_MULT  = 3600;
	localparam int MV_SHIFT = 12;

	localparam int RATE_MAX = 255;

	localparam logic [MARGIN_W-1:0] RISE_MARGIN_RST = MARGIN_W'(7);
	localparam logic [GAP_W-1:0]    MIN_GAP_RST     = GAP_W'(1000);
	localparam logic [WINDOW_W-1:0] WINDOW_RST      = WINDOW_W'(20000);
	localparam logic [SCALE_W-1:0]  RATE_SCALE_RST  = SCALE_W'(3);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RISE_MARGIN = 2'd0,
		REG_MIN_GAP     = 2'd1,
		REG_WINDOW      = 2'd2,
		REG_RATE_SCALE  = 2'd3
	} bre_reg_t;

	typedef struct packed {
		logic signed [MV_W-1:0] mv;
		logic [NOW_W-1:0]       now_ms;
	} bre_item_t;

	typedef struct packed {
		logic [MARGIN_W-1:0] rise_margin;
		logic [GAP_W-1:0]    min_peak_gap_ms;
		logic [WINDOW_W-1:0] window_ms;
		logic [SCALE_W-1:0]  rate_scale;
	} bre_cfg_t;

endpackage

### sv/bre_if.sv
`timescale 1ns / 1ps
// bre_in_if and bre_out_if: valid/ready channels of the breathing rate
// estimator. Depends on bre_pkg.
interface bre_in_if;
	import bre_pkg::*;
	logic                    valid;
	logic                    ready;
	logic signed [RAW_W-1:0] raw_sample;
	logic [NOW_W-1:0]        now_ms;
	modport source(output valid, raw_sample, now_ms, input ready);
	modport sink(input valid, raw_sample, now_ms, output ready);
endinterface

interface bre_out_if;
	import bre_pkg::*;
	logic                   valid;
	logic                   ready;
	logic signed [MV_W-1:0] smoothed_mv;
	logic [RATE_W-1:0]      breaths_per_min;
	modport source(output valid, smoothed_mv, breaths_per_min, input ready);
	modport sink(input valid, smoothed_mv, breaths_per_min, output ready);
endinterface

### sv/bre_front.sv
`timescale 1ns / 1ps
// bre_front: takes sample requests, converts them to millivolts and hands
// them to the queue. Depends on bre_pkg and bre_if.
module bre_front (
	input  logic               clk,
	input  logic               arst_n,
	bre_in_if.sink             sample,
	output logic               push_valid,
	input  logic               push_ready,
	output bre_pkg::bre_item_t push_item
);
	import bre_pkg::*;

	localparam int PROD_W = RAW_W + MV_SHIFT;
	localparam logic signed [PROD_W-1:0] MULT_K    = PROD_W'(MV_MULT);
	localparam logic signed [PROD_W-1:0] ROUND_ADD = PROD_W'((1 << MV_SHIFT) - 1);

	logic                     valid_s1;
	bre_item_t                item_s1;
	logic signed [PROD_W-1:0] raw_ext;
	logic signed [PROD_W-1:0] scaled;
	logic signed [PROD_W-1:0] adj;
	logic                     take;

	assign sample.ready = !valid_s1 || push_ready;
	assign take         = sample.valid && sample.ready;

	// truncation toward zero
	always_comb begin
		raw_ext = PROD_W'(sample.raw_sample);
		scaled  = raw_ext * MULT_K;
		adj     = scaled + (scaled[PROD_W-1] ? ROUND_ADD : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			item_s1  <= '0;
		end else begin
			if (take) begin
				valid_s1       <= 1'b1;
				item_s1.mv     <= adj[PROD_W-1:MV_SHIFT];
				item_s1.now_ms <= sample.now_ms;
			end else if (push_ready) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	assign push_valid = valid_s1;
	assign push_item  = item_s1;
endmodule

### sv/bre_queue.sv
`timescale 1ns / 1ps
// bre_queue: short request queue between the front and the back unit.
// Depends on bre_pkg.
module bre_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push_valid,
	output logic               push_ready,
	input  bre_pkg::bre_item_t push_item,
	output logic               pop_valid,
	input  logic               pop_ready,
	output bre_pkg::bre_item_t pop_item
);
	import bre_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

	bre_item_t        entries_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = cnt_q != CNT_W'(QUEUE_DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_item   = entries_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
			for (int i = 0; i < QUEUE_DEPTH; i++) begin
				entries_q[i] <= '0;
			end
		end else begin
			if (do_push) begin
				entries_q[wr_q] <= push_item;
				wr_q <= (wr_q == PTR_LAST) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_LAST) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end
endmodule

### sv/bre_back.sv
`timescale 1ns / 1ps
// bre_back: moving average, peak detection, peak stamp ring and rate count,
// with the result register. Depends on bre_pkg and bre_if.
module bre_back #(
	parameter int AVG_TAPS   = bre_pkg::AVG_TAPS_DEF,
	parameter int PEAK_SLOTS = bre_pkg::PEAK_SLOTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  bre_pkg::bre_cfg_t  cfg,
	input  logic               pop_valid,
	output logic               pop_ready,
	input  bre_pkg::bre_item_t pop_item,
	bre_out_if.source          result
);
	import bre_pkg::*;

	localparam int AVG_IDX_W  = (AVG_TAPS > 1) ? $clog2(AVG_TAPS) : 1;
	localparam int PEAK_IDX_W = (PEAK_SLOTS > 1) ? $clog2(PEAK_SLOTS) : 1;
	localparam int CNT_W      = $clog2(PEAK_SLOTS + 1);
	localparam int SUM_W      = MV_W + $clog2(AVG_TAPS) + 1;
	localparam int RECIP_K    = SUM_W;
	localparam int MUL_W      = 2 * SUM_W + 1;
	localparam int FIX_W      = SUM_W + 5;
	localparam int CMP_W      = MV_W + 2;
	localparam int RFULL_W    = (CNT_W + SCALE_W > RATE_W) ? CNT_W + SCALE_W : RATE_W;
	localparam logic [SUM_W:0] RECIP = (SUM_W + 1)'((1 << RECIP_K) / AVG_TAPS);
	localparam logic [AVG_IDX_W-1:0]  AVG_LAST  = AVG_IDX_W'(AVG_TAPS - 1);
	localparam logic [PEAK_IDX_W-1:0] PEAK_LAST = PEAK_IDX_W'(PEAK_SLOTS - 1);

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_ABS  = 7'b0000010,
		ST_MUL  = 7'b0000100,
		ST_FIX  = 7'b0001000,
		ST_PEAK = 7'b0010000,
		ST_WALK = 7'b0100000,
		ST_OUT  = 7'b1000000
	} bre_state_t;

	bre_state_t              state_q;
	logic signed [MV_W-1:0]  taps_q [AVG_TAPS];
	logic signed [SUM_W-1:0] sum_q;
	logic [AVG_IDX_W-1:0]    avg_slot_q;
	logic [NOW_W-1:0]        now_q;
	logic [SUM_W-1:0]        abs_q;
	logic                    neg_q;
	logic [SUM_W-1:0]        quo_q;
	logic signed [MV_W-1:0]  avg_q;
	logic signed [MV_W-1:0]  prev_q;
	logic                    rising_q;
	logic [NOW_W-1:0]        last_peak_q;
	logic [NOW_W-1:0]        stamps_q [PEAK_SLOTS];
	logic [PEAK_IDX_W-1:0]   stamp_slot_q;
	logic [PEAK_IDX_W-1:0]   walk_q;
	logic [CNT_W-1:0]        count_q;
	logic                    out_valid_q;
	logic signed [MV_W-1:0]  out_mv_q;
	logic [RATE_W-1:0]       out_rate_q;

	logic signed [SUM_W-1:0] new_sum;
	logic [MUL_W-1:0]        prod;
	logic [FIX_W-1:0]        qn;
	logic [FIX_W-1:0]        rem;
	logic [SUM_W-1:0]        qc;
	logic [SUM_W-1:0]        qs;
	logic signed [CMP_W-1:0] avg_ext;
	logic signed [CMP_W-1:0] thr;
	logic                    peak;
	logic                    fall;
	logic                    gap_ok;
	logic [NOW_W-1:0]        age;
	logic                    in_window;
	logic [RFULL_W-1:0]      rate_full;
	logic [RATE_W-1:0]       rate_sat;
	logic                    out_free;

	always_comb begin
		new_sum   = sum_q - SUM_W'(taps_q[avg_slot_q]) + SUM_W'(pop_item.mv);
		prod      = MUL_W'(abs_q) * MUL_W'(RECIP);
		qn        = FIX_W'(quo_q) * FIX_W'(AVG_TAPS);
		rem       = FIX_W'(abs_q) - qn;
		qc        = (rem >= FIX_W'(AVG_TAPS)) ? quo_q + 1'b1 : quo_q;
		qs        = neg_q ? (~qc + 1'b1) : qc;
		avg_ext   = CMP_W'(avg_q);
		thr       = CMP_W'(prev_q) + CMP_W'($signed({1'b0, cfg.rise_margin}));
		fall      = rising_q && (avg_q < prev_q);
		peak      = !rising_q && (avg_ext > thr);
		gap_ok    = (now_q - last_peak_q) >= NOW_W'(cfg.min_peak_gap_ms);
		age       = now_q - stamps_q[walk_q];
		in_window = age <= NOW_W'(cfg.window_ms);
		rate_full = RFULL_W'(count_q) * RFULL_W'(cfg.rate_scale);
		rate_sat  = (rate_full > RFULL_W'(RATE_MAX)) ? RATE_W'(RATE_MAX)
		                                             : rate_full[RATE_W-1:0];
		out_free  = !out_valid_q || result.ready;
	end

	assign pop_ready              = state_q == ST_IDLE;
	assign result.valid           = out_valid_q;
	assign result.smoothed_mv     = out_mv_q;
	assign result.breaths_per_min = out_rate_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			sum_q        <= '0;
			avg_slot_q   <= '0;
			now_q        <= '0;
			abs_q        <= '0;
			neg_q        <= 1'b0;
			quo_q        <= '0;
			avg_q        <= '0;
			prev_q       <= '0;
			rising_q     <= 1'b0;
			last_peak_q  <= '0;
			stamp_slot_q <= '0;
			walk_q       <= '0;
			count_q      <= '0;
			out_valid_q  <= 1'b0;
			out_mv_q     <= '0;
			out_rate_q   <= '0;
			for (int i = 0; i < AVG_TAPS; i++) begin
				taps_q[i] <= '0;
			end
			for (int i = 0; i < PEAK_SLOTS; i++) begin
				stamps_q[i] <= '0;
			end
		end else begin
			if (state_q == ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result.valid && result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop_valid) begin
						taps_q[avg_slot_q] <= pop_item.mv;
						sum_q      <= new_sum;
						avg_slot_q <= (avg_slot_q == AVG_LAST) ? '0 : avg_slot_q + 1'b1;
						now_q      <= pop_item.now_ms;
						state_q    <= ST_ABS;
					end
				end
				ST_ABS: begin
					neg_q   <= sum_q[SUM_W-1];
					abs_q   <= sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					quo_q   <= prod[RECIP_K +: SUM_W];
					state_q <= ST_FIX;
				end
				ST_FIX: begin
					avg_q   <= qs[MV_W-1:0];
					state_q <= ST_PEAK;
				end
				ST_PEAK: begin
					if (fall) begin
						rising_q <= 1'b0;
					end else if (peak) begin
						rising_q <= 1'b1;
					end
					if (peak && gap_ok) begin
						last_peak_q            <= now_q;
						stamps_q[stamp_slot_q] <= now_q;
						stamp_slot_q <= (stamp_slot_q == PEAK_LAST) ? '0
						                                            : stamp_slot_q + 1'b1;
					end
					prev_q  <= avg_q;
					walk_q  <= '0;
					count_q <= '0;
					state_q <= ST_WALK;
				end
				ST_WALK: begin
					if (in_window) begin
						count_q <= count_q + 1'b1;
					end
					if (walk_q == PEAK_LAST) begin
						state_q <= ST_OUT;
					end else begin
						walk_q <= walk_q + 1'b1;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						out_mv_q    <= avg_q;
						out_rate_q  <= rate_sat;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end
endmodule

### sv/breathing_rate_estimator_unit.sv
`timescale 1ns / 1ps
// breathing_rate_estimator_unit: top level with the configuration registers.
// Depends on bre_pkg, bre_if, bre_front, bre_queue and bre_back.
//
// Each sample request gives one result: the moving average over AVG_TAPS
// samples (five by default) in millivolts and the breath rate, the count of
// stored peak stamps inside window_ms times rate_scale. The time the back
// unit takes per sample is set by the walk over the peak stamp ring, one
// stamp a cycle; a one-stage front and a two-entry queue take further
// samples meanwhile, and the result register holds a finished result until
// it is taken. Registers are written through cfg_wr_en, cfg_index and
// cfg_wdata, by the user only while no sample is in flight; the block does not enforce it.
module breathing_rate_estimator_unit #(
	parameter int AVG_TAPS   = bre_pkg::AVG_TAPS_DEF,
	parameter int PEAK_SLOTS = bre_pkg::PEAK_SLOTS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [bre_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bre_pkg::CFG_W-1:0]      cfg_wdata,
	bre_in_if.sink                         sample,
	bre_out_if.source                      result
);
	import bre_pkg::*;

	bre_cfg_t  cfg_q;
	logic      push_valid;
	logic      push_ready;
	bre_item_t push_item;
	logic      pop_valid;
	logic      pop_ready;
	bre_item_t pop_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rise_margin     <= RISE_MARGIN_RST;
			cfg_q.min_peak_gap_ms <= MIN_GAP_RST;
			cfg_q.window_ms       <= WINDOW_RST;
			cfg_q.rate_scale      <= RATE_SCALE_RST;
		end else if (cfg_wr_en) begin
			case (bre_reg_t'(cfg_index))
				REG_RISE_MARGIN: cfg_q.rise_margin     <= cfg_wdata[MARGIN_W-1:0];
				REG_MIN_GAP:     cfg_q.min_peak_gap_ms <= cfg_wdata[GAP_W-1:0];
				REG_WINDOW:      cfg_q.window_ms       <= cfg_wdata[WINDOW_W-1:0];
				REG_RATE_SCALE:  cfg_q.rate_scale      <= cfg_wdata[SCALE_W-1:0];
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	bre_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.sample     (sample),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	bre_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	bre_back #(
		.AVG_TAPS   (AVG_TAPS),
		.PEAK_SLOTS (PEAK_SLOTS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_item  (pop_item),
		.result    (result)
	);
endmodule
